### rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator: opcodes,
// status codes, request and result payloads, and the block descriptor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

  localparam int HEAP_BYTES_DEF   = 65536;
  localparam int HEADER_BYTES_DEF = 12;
  localparam int MAX_BLOCKS_DEF   = 1024;

  localparam int ADDR_W = 16;
  localparam int HDR_W  = 16;
  localparam int SIZE_W = 17;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RESIZE  = 2'd2,
    OP_CALLOC  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_GRANTED  = 2'd0,
    ST_NULL     = 2'd1,
    ST_RELEASED = 2'd2,
    ST_UNKNOWN  = 2'd3
  } status_t;

  typedef struct packed {
    op_t               opcode;
    logic [ADDR_W-1:0] request_bytes;
    logic [ADDR_W-1:0] element_count;
    logic [ADDR_W-1:0] payload_address;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    status_t           status;
    logic [ADDR_W-1:0] copy_source;
    logic [ADDR_W-1:0] copy_length;
    logic              zero_fill;
  } out_t;

  typedef struct packed {
    logic [HDR_W-1:0]  hdr;
    logic [SIZE_W-1:0] size;
    logic              free;
  } desc_t;

endpackage

`default_nettype wire

### rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffha_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with bump pointer over a descriptor RAM.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready, one at a time; results leave on
// out_valid/out_ready through an output register, so the next request is
// taken while a finished result still waits for the receiver.
// Descriptors live in one RAM with a registered read; each search reads one
// descriptor per cycle, pipelined, over the RAM read port, in this order:
//   allocate: live descriptors newest to oldest, then the bump pointer
//   release: address lookup, oldest to newest
//   resize: lookup, then a fresh allocation if the block is too small
//   zeroed array: an extra state for the count times size product
// A stalled receiver holds the result register; a further result waits in
// the final state until the register drains.
// Reset (rst_n low, synchronous) empties the heap: descriptor count and top
// pointer go to zero. Descriptor RAM contents need no clearing, since only
// entries below the count are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ffha_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ffha_pkg::out_t     out_data
);

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int SIZE_W = ffha_pkg::SIZE_W;
  localparam int ADDR_W = ffha_pkg::ADDR_W;
  localparam int SUM_W  = SIZE_W + 1;
  localparam int PROD_W = 2 * ADDR_W;
  localparam int DESC_W = $bits(ffha_pkg::desc_t);

  localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_BLOCKS);
  localparam logic [SUM_W-1:0]  HDR_SUM  = SUM_W'(HEADER_BYTES);
  localparam logic [SUM_W-1:0]  HEAP_SUM = SUM_W'(HEAP_BYTES);
  localparam logic [PROD_W-1:0] HEAP_PRD = PROD_W'(HEAP_BYTES);
  localparam logic [SIZE_W-1:0] HDR_SZ   = SIZE_W'(HEADER_BYTES);
  localparam logic [ADDR_W-1:0] HDR_AD   = ADDR_W'(HEADER_BYTES);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL    = 7'b0000010,
    S_GSTART = 7'b0000100,
    S_GRANT  = 7'b0001000,
    S_BUMP   = 7'b0010000,
    S_LOOK   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  ffha_pkg::op_t           op_r, op_nxt;
  logic [ADDR_W-1:0]       req_r, req_nxt;
  logic [ADDR_W-1:0]       elem_r, elem_nxt;
  logic [ADDR_W-1:0]       addr_r, addr_nxt;
  logic [SIZE_W-1:0]       size_r, size_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]       top_r, top_nxt;
  logic [IDX_W-1:0]        scan_r, scan_nxt;
  logic [IDX_W-1:0]        chk_r, chk_nxt;
  logic                    issue_r, issue_nxt;
  logic                    pend_r, pend_nxt;
  ffha_pkg::desc_t         old_r, old_nxt;
  logic [IDX_W-1:0]        old_idx_r, old_idx_nxt;
  logic                    free_old_r, free_old_nxt;
  ffha_pkg::out_t          res_r, res_nxt;
  ffha_pkg::out_t          out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  ffha_pkg::desc_t         ram_wdata;
  logic                    ram_re;
  logic [IDX_W-1:0]        ram_raddr;
  logic [DESC_W-1:0]       ram_rdata;
  ffha_pkg::desc_t         rd_desc;

  logic                    g_fin;
  logic [ADDR_W-1:0]       g_addr;
  logic                    g_ok;
  logic                    g_move;
  logic                    g_bad;
  logic [SIZE_W-1:0]       g_size;
  logic [SUM_W-1:0]        bump_sum;
  logic                    look_hit;

  assign rd_desc   = ffha_pkg::desc_t'(ram_rdata);
  assign g_size    = (op_r == ffha_pkg::OP_CALLOC) ? prod_r[SIZE_W-1:0] : size_r;
  assign bump_sum  = {1'b0, top_r} + HDR_SUM + {1'b0, size_r};
  assign look_hit  = ({1'b0, rd_desc.hdr} + HDR_SZ) == {1'b0, addr_r};

  ffha_ram #(
    .WIDTH(DESC_W),
    .DEPTH(MAX_BLOCKS)
  ) u_desc_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    req_nxt       = req_r;
    elem_nxt      = elem_r;
    addr_nxt      = addr_r;
    size_nxt      = size_r;
    prod_nxt      = prod_r;
    cnt_nxt       = cnt_r;
    top_nxt       = top_r;
    scan_nxt      = scan_r;
    chk_nxt       = chk_r;
    issue_nxt     = issue_r;
    pend_nxt      = pend_r;
    old_nxt       = old_r;
    old_idx_nxt   = old_idx_r;
    free_old_nxt  = free_old_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = chk_r;
    ram_wdata     = rd_desc;
    ram_re        = 1'b0;
    ram_raddr     = scan_r;
    g_fin         = 1'b0;
    g_addr        = '0;
    g_bad         = 1'b0;
    in_ready      = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_data.opcode;
          req_nxt      = in_data.request_bytes;
          elem_nxt     = in_data.element_count;
          addr_nxt     = in_data.payload_address;
          size_nxt     = {1'b0, in_data.request_bytes};
          free_old_nxt = 1'b0;
          issue_nxt    = 1'b0;
          pend_nxt     = 1'b0;
          res_nxt      = '0;
          case (in_data.opcode)
            ffha_pkg::OP_ALLOC: begin
              state_nxt = S_GSTART;
            end
            ffha_pkg::OP_CALLOC: begin
              state_nxt = S_MUL;
            end
            default: begin
              if (in_data.payload_address == '0) begin
                if (in_data.opcode == ffha_pkg::OP_RELEASE) begin
                  res_nxt.status = ffha_pkg::ST_RELEASED;
                  state_nxt      = S_DONE;
                end else begin
                  state_nxt = S_GSTART;
                end
              end else if (cnt_r == '0) begin
                res_nxt.status = ffha_pkg::ST_UNKNOWN;
                state_nxt      = S_DONE;
              end else begin
                scan_nxt  = '0;
                issue_nxt = 1'b1;
                state_nxt = S_LOOK;
              end
            end
          endcase
        end
      end

      S_MUL: begin
        prod_nxt  = PROD_W'(elem_r) * PROD_W'(req_r);
        state_nxt = S_GSTART;
      end

      S_GSTART: begin
        size_nxt  = g_size;
        issue_nxt = 1'b0;
        pend_nxt  = 1'b0;
        if (op_r == ffha_pkg::OP_CALLOC) begin
          g_bad = (prod_r == '0) || (prod_r > HEAP_PRD);
        end else begin
          g_bad = (size_r == '0);
        end
        if (g_bad) begin
          g_fin = 1'b1;
        end else if (cnt_r == '0) begin
          state_nxt = S_BUMP;
        end else begin
          scan_nxt  = IDX_W'(cnt_r - CNT_ONE);
          issue_nxt = 1'b1;
          state_nxt = S_GRANT;
        end
      end

      S_GRANT: begin
        pend_nxt = issue_r;
        if (issue_r) begin
          ram_re    = 1'b1;
          ram_raddr = scan_r;
          chk_nxt   = scan_r;
          if (scan_r == '0) begin
            issue_nxt = 1'b0;
          end else begin
            scan_nxt = scan_r - IDX_W'(1);
          end
        end
        if (pend_r) begin
          if (rd_desc.free && (rd_desc.size >= size_r)) begin
            ram_we         = 1'b1;
            ram_waddr      = chk_r;
            ram_wdata      = rd_desc;
            ram_wdata.free = 1'b0;
            g_fin          = 1'b1;
            g_addr         = rd_desc.hdr + HDR_AD;
            issue_nxt      = 1'b0;
          end else if (chk_r == '0) begin
            state_nxt = S_BUMP;
          end
        end
      end

      S_BUMP: begin
        g_fin = 1'b1;
        if ((cnt_r < CNT_MAX) && (bump_sum <= HEAP_SUM)) begin
          ram_we         = 1'b1;
          ram_waddr      = cnt_r[IDX_W-1:0];
          ram_wdata.hdr  = top_r[ADDR_W-1:0];
          ram_wdata.size = size_r;
          ram_wdata.free = 1'b0;
          cnt_nxt        = cnt_r + CNT_ONE;
          top_nxt        = bump_sum[SIZE_W-1:0];
          g_addr         = top_r[ADDR_W-1:0] + HDR_AD;
        end
      end

      S_LOOK: begin
        pend_nxt = issue_r;
        if (issue_r) begin
          ram_re    = 1'b1;
          ram_raddr = scan_r;
          chk_nxt   = scan_r;
          if ((CNT_W'(scan_r) + CNT_ONE) == cnt_r) begin
            issue_nxt = 1'b0;
          end else begin
            scan_nxt = scan_r + IDX_W'(1);
          end
        end
        if (pend_r) begin
          if (look_hit) begin
            old_nxt     = rd_desc;
            old_idx_nxt = chk_r;
            issue_nxt   = 1'b0;
            res_nxt     = '0;
            if ((op_r == ffha_pkg::OP_RELEASE) || (req_r == '0)) begin
              ram_we         = 1'b1;
              ram_waddr      = chk_r;
              ram_wdata      = rd_desc;
              ram_wdata.free = 1'b1;
              res_nxt.status = ffha_pkg::ST_RELEASED;
              state_nxt      = S_DONE;
            end else if (rd_desc.size >= {1'b0, req_r}) begin
              res_nxt.result_address = addr_r;
              res_nxt.status         = ffha_pkg::ST_GRANTED;
              state_nxt              = S_DONE;
            end else begin
              size_nxt  = {1'b0, req_r};
              state_nxt = S_GSTART;
            end
          end else if ((CNT_W'(chk_r) + CNT_ONE) == cnt_r) begin
            res_nxt        = '0;
            res_nxt.status = ffha_pkg::ST_UNKNOWN;
            state_nxt      = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (free_old_r) begin
          ram_we         = 1'b1;
          ram_waddr      = old_idx_r;
          ram_wdata      = old_r;
          ram_wdata.free = 1'b1;
          free_old_nxt   = 1'b0;
        end
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    g_ok   = (g_addr != '0);
    g_move = g_ok && (op_r == ffha_pkg::OP_RESIZE) && (addr_r != '0);
    if (g_fin) begin
      res_nxt                = '0;
      res_nxt.result_address = g_addr;
      res_nxt.status         = g_ok ? ffha_pkg::ST_GRANTED : ffha_pkg::ST_NULL;
      res_nxt.zero_fill      = g_ok && (op_r == ffha_pkg::OP_CALLOC);
      if (g_move) begin
        res_nxt.copy_source = addr_r;
        res_nxt.copy_length = old_r.size[ADDR_W-1:0];
      end
      free_old_nxt = g_move;
      state_nxt    = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      top_r       <= '0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      free_old_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      top_r       <= top_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      free_old_r  <= free_old_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    req_r     <= req_nxt;
    elem_r    <= elem_nxt;
    addr_r    <= addr_nxt;
    size_r    <= size_nxt;
    prod_r    <= prod_nxt;
    scan_r    <= scan_nxt;
    chk_r     <= chk_nxt;
    old_r     <= old_nxt;
    old_idx_r <= old_idx_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### rtl/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the first-fit heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffha_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire ffha_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented right after reset");

  a_grant_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.status == ffha_pkg::ST_GRANTED) ==
                   (out_data.result_address != '0)))
    else $error("granted status and result address disagree");

  a_side_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.zero_fill || (out_data.copy_source != '0)) |->
      (out_data.status == ffha_pkg::ST_GRANTED) &&
      !(out_data.zero_fill && (out_data.copy_source != '0)))
    else $error("copy or zero-fill flagged on a result that grants nothing");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire
